[src/matrix_multiply_accumulate_core_assert.svh]
// assertion macros for the matrix multiply-accumulate core
// expects clk and rst in the scope of the including module
`ifndef MATRIX_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every clock edge out of reset
`define MMAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every clock edge out of reset
`define MMAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MMAC_ASSERT_IMP(lbl, ante, cons, msg)
`define MMAC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[src/mmac_pkg.sv]
// shared type, constants and arithmetic helper of the matrix multiply-accumulate core
// no dependencies
package mmac_pkg;

  // default store dimensions
  localparam int DEF_MAX_ROWS  = 16;
  localparam int DEF_MAX_INNER = 32;
  localparam int DEF_MAX_COLS  = 32;

  // field widths
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 5;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 40;
  localparam int OUT_ROW_W   = 4;
  localparam int OUT_COL_W   = 5;
  localparam int ROWS_REG_W  = 5;
  localparam int INNER_REG_W = 6;
  localparam int COLS_REG_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;

  // configuration reset values
  localparam logic [ROWS_REG_W-1:0]  NUM_ROWS_RST  = 5'd1;
  localparam logic [INNER_REG_W-1:0] INNER_LEN_RST = 6'd16;
  localparam logic [COLS_REG_W-1:0]  NUM_COLS_RST  = 6'd32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_X  = 2'd0,
    CMD_LOAD_W  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  // accumulator plus product, clipped to the signed accumulator range
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  base,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(base) + (ACC_W+1)'(prod);
    if (s[ACC_W] != s[ACC_W-1]) begin
      if (s[ACC_W]) begin
        sat_add = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
        sat_add = {1'b0, {(ACC_W-1){1'b1}}};
      end
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

[src/matrix_multiply_accumulate_core.sv]
// matrix multiply-accumulate core: C += X * W over three on-chip stores
// depends on mmac_pkg and matrix_multiply_accumulate_core_assert.svh
//
//  channel  handshake             payload
//  -------  --------------------  --------------------------------------------------
//  in       in_valid / in_stall   cmd, first_index, second_index, elem_value, acc_init
//  out      out_valid / out_stall out_row, out_col, out_value, last
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// loads can follow each other every cycle while in_stall stays low
// a compute row runs n = cols * max(inner, 1) multiply-accumulate steps, clamped counts:
// the command, one step per cycle while no result stalls, then the pipeline drains
// after reset a clearing pass zeroes all 2**(row bits + col bits) c store entries
// (512 at the default sizes) with in_stall high; configuration writes are taken
// a stalled result freezes the whole multiply-accumulate pipeline in place
`include "matrix_multiply_accumulate_core_assert.svh"

module matrix_multiply_accumulate_core
  import mmac_pkg::*;
#(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_INNER = DEF_MAX_INNER,
  parameter int MAX_COLS  = DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     rst,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_W-1:0]         first_index,
  input  logic [IDX_W-1:0]         second_index,
  input  logic signed [ELEM_W-1:0] elem_value,
  input  logic signed [ACC_W-1:0]  acc_init,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_ROW_W-1:0]     out_row,
  output logic [OUT_COL_W-1:0]     out_col,
  output logic signed [ACC_W-1:0]  out_value,
  output logic                     last,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int X_DEPTH = 1 << (RW + IW);
  localparam int W_DEPTH = 1 << (IW + CW);
  localparam int C_DEPTH = 1 << (RW + CW);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

  // per-step control carried along the multiply-accumulate pipeline
  typedef struct packed {
    logic          first;
    logic          last_k;
    logic          last_col;
    logic          zero;
    logic [CW-1:0] col;
  } tag_t;

  state_t state;
  logic [RW+CW-1:0] clr_addr;

  logic [ROWS_REG_W-1:0]  num_rows;
  logic [INNER_REG_W-1:0] inner_len;
  logic [COLS_REG_W-1:0]  num_cols;

  // current row command
  logic [IDX_W-1:0] cur_a;
  logic [IW-1:0]    k;
  logic [IW-1:0]    kend;
  logic [CW-1:0]    j;
  logic [CW-1:0]    jend;
  logic             zero_run;

  // stores
  logic signed [ELEM_W-1:0] x_mem [X_DEPTH];
  logic signed [ELEM_W-1:0] w_mem [W_DEPTH];
  logic signed [ACC_W-1:0]  c_mem [C_DEPTH];

  // pipeline registers
  logic                     v1;
  logic                     v2;
  tag_t                     tag0;
  tag_t                     tag1;
  tag_t                     tag2;
  logic signed [ELEM_W-1:0] x_q;
  logic signed [ELEM_W-1:0] w_q;
  logic signed [ACC_W-1:0]  c_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p2;
  logic signed [ACC_W-1:0]  c2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum;

  logic        adv;
  logic        issue;
  logic        accept;
  logic        writeback;
  cmd_t        cmd_in;
  logic [31:0] a_ext;
  logic [31:0] b_ext;
  logic [31:0] inner_eff;
  logic [31:0] cols_eff;
  logic        x_load;
  logic        w_load;
  logic        c_load;
  logic        start_ok;
  logic [RW-1:0] row_addr;

  logic                    c_we;
  logic [RW+CW-1:0]        c_waddr;
  logic signed [ACC_W-1:0] c_wdata;

  assign cfg_ready = 1'b1;

  // handshake and decode of the incoming transaction
  assign in_stall = !((state == ST_IDLE) && !v1 && !v2);
  assign accept   = in_valid && !in_stall;
  assign adv      = !(out_valid && out_stall);
  assign issue    = (state == ST_RUN) && adv;
  assign row_addr = RW'(cur_a);

  always_comb begin
    cmd_in    = cmd_t'(cmd);
    a_ext     = 32'(first_index);
    b_ext     = 32'(second_index);
    inner_eff = (32'(inner_len) < 32'(MAX_INNER)) ? 32'(inner_len) : 32'(MAX_INNER);
    cols_eff  = (32'(num_cols) < 32'(MAX_COLS)) ? 32'(num_cols) : 32'(MAX_COLS);
    x_load    = accept && (cmd_in == CMD_LOAD_X) &&
                (a_ext < 32'(MAX_ROWS)) && (b_ext < 32'(MAX_INNER));
    w_load    = accept && (cmd_in == CMD_LOAD_W) &&
                (a_ext < 32'(MAX_INNER)) && (b_ext < 32'(MAX_COLS));
    c_load    = accept && (cmd_in == CMD_LOAD_C) &&
                (a_ext < 32'(MAX_ROWS)) && (b_ext < 32'(MAX_COLS));
    start_ok  = accept && (cmd_in == CMD_COMPUTE) && (a_ext < 32'(num_rows)) &&
                (a_ext < 32'(MAX_ROWS)) && (cols_eff != 32'd0);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= NUM_ROWS_RST;
      inner_len <= INNER_LEN_RST;
      num_cols  <= NUM_COLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS:  num_rows  <= cfg_data[ROWS_REG_W-1:0];
        CFG_INNER_LEN: inner_len <= cfg_data[INNER_REG_W-1:0];
        CFG_NUM_COLS:  num_cols  <= cfg_data[COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: clearing pass, command start, step issue, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == {(RW+CW){1'b1}}) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (start_ok) begin
            state    <= ST_RUN;
            cur_a    <= first_index;
            k        <= '0;
            j        <= '0;
            kend     <= (inner_eff == 32'd0) ? '0 : IW'(inner_eff - 32'd1);
            jend     <= CW'(cols_eff - 32'd1);
            zero_run <= (inner_eff == 32'd0);
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (k == kend) begin
              k <= '0;
              if (j == jend) begin
                state <= ST_IDLE;
              end else begin
                j <= j + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (adv) begin
        out_valid <= writeback;
        if (writeback) begin
          out_row   <= cur_a[OUT_ROW_W-1:0];
          out_col   <= OUT_COL_W'(tag2.col);
          out_value <= sum;
          last      <= tag2.last_col;
        end
      end
    end
  end

  // x and w stores: loads write, issued steps read
  always_ff @(posedge clk) begin
    if (x_load) begin
      x_mem[{RW'(first_index), IW'(second_index)}] <= elem_value;
    end
    if (issue) begin
      x_q <= x_mem[{row_addr, k}];
    end
  end

  always_ff @(posedge clk) begin
    if (w_load) begin
      w_mem[{IW'(first_index), CW'(second_index)}] <= elem_value;
    end
    if (issue) begin
      w_q <= w_mem[{k, j}];
    end
  end

  // c store write port: clearing pass, loads and write-back never overlap
  always_comb begin
    c_we    = 1'b0;
    c_waddr = clr_addr;
    c_wdata = '0;
    if (state == ST_CLEAR) begin
      c_we = 1'b1;
    end else if (c_load) begin
      c_we    = 1'b1;
      c_waddr = {RW'(first_index), CW'(second_index)};
      c_wdata = acc_init;
    end else if (writeback && adv) begin
      c_we    = 1'b1;
      c_waddr = {row_addr, tag2.col};
      c_wdata = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (issue) begin
      c_q <= c_mem[{row_addr, j}];
    end
  end

  // step tag at issue
  always_comb begin
    tag0.first    = (k == '0);
    tag0.last_k   = (k == kend);
    tag0.last_col = (j == jend);
    tag0.zero     = zero_run;
    tag0.col      = j;
  end

  // multiply and accumulate stages
  assign prod      = x_q * w_q;
  assign sum       = sat_add(tag2.first ? c2 : acc, p2);
  assign writeback = v2 && tag2.last_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (issue) begin
        tag1 <= tag0;
      end
      tag2 <= tag1;
      c2   <= c_q;
      p2   <= tag1.zero ? '0 : prod;
      if (v2) begin
        acc <= sum;
      end
    end
  end

  // checks
  `MMAC_ASSERT_IMP(a_counters_in_range, state == ST_RUN, (k <= kend) && (j <= jend), "overrun")
  `MMAC_ASSERT_NXT(a_result_registered, writeback && adv, out_valid, "result lost")
  `MMAC_ASSERT_NXT(a_frozen_on_stall, !adv, $stable({acc, v2, tag2}), "moved on stall")

endmodule
